FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checks a plain condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    `ASSERT_CLK(lbl, clk, rstn, (cond))

`endif

FILE: hdl/lz4d_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder package
// Shared payload types, operation codes, parse phases and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package lz4d_pkg;

    localparam int unsigned WINDOW_BYTES = 65536;
    localparam int unsigned ADDR_W = 16;

    localparam logic [1:0] OP_FEED  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BADOFF = 2'd1;
    localparam logic [1:0] STATUS_TRUNC  = 2'd2;

    localparam logic [7:0] LEN_EXTEND = 8'd255;
    localparam logic [3:0] NIBBLE_EXT = 4'd15;
    localparam logic [7:0] MATCH_MIN  = 8'd4;

    typedef enum logic [2:0] {
        PH_TOKEN    = 3'd0,
        PH_LITLEN   = 3'd1,
        PH_LITERALS = 3'd2,
        PH_OFFLO    = 3'd3,
        PH_OFFHI    = 3'd4,
        PH_MATCHLEN = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_EMIT,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic copy_rd;
        logic copy_wr;
        logic emit;
        logic emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic copy_go;
        logic copy_done;
        logic pack_full;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/lz4d_ctrl.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder controller
// Sequences decode, byte copy and result transfers for one input item.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  lz4d_pkg::dp_status_t dp_status,
    output lz4d_pkg::dp_cmd_t    dp_cmd
);
    import lz4d_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                state_next = dp_status.copy_go ? ST_COPY_RD : ST_FLUSH;
            end
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (dp_status.copy_done) state_next = ST_FLUSH;
                else if (dp_status.pack_full) state_next = ST_EMIT;
                else state_next = ST_COPY_RD;
            end
            ST_EMIT: begin
                if (dp_status.out_free) state_next = ST_COPY_RD;
            end
            ST_FLUSH: begin
                if (dp_status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        dp_cmd           = '0;
        dp_cmd.load      = (state_reg == ST_IDLE) && s_valid;
        dp_cmd.decode    = (state_reg == ST_DECODE);
        dp_cmd.copy_rd   = (state_reg == ST_COPY_RD);
        dp_cmd.copy_wr   = (state_reg == ST_COPY_WR);
        dp_cmd.emit      = ((state_reg == ST_EMIT) || (state_reg == ST_FLUSH))
                           && dp_status.out_free;
        dp_cmd.emit_last = (state_reg == ST_FLUSH);
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_wr_after_rd, aclk, aresetn, dp_cmd.copy_wr |-> $past(dp_cmd.copy_rd))
    `ASSERT_CLK(a_load_to_decode, aclk, aresetn, dp_cmd.load |=> dp_cmd.decode)
    `ASSERT_CLK(a_flush_to_idle, aclk, aresetn, (dp_cmd.emit && dp_cmd.emit_last) |=> s_ready)

endmodule

`default_nettype wire

FILE: hdl/lz4d_datapath.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder datapath
// Parse state, history window memory, output packing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4d_datapath #(
    parameter int unsigned OUT_LANES = 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  lz4d_pkg::in_item_t   s_payload,
    input  lz4d_pkg::dp_cmd_t    dp_cmd,
    output lz4d_pkg::dp_status_t dp_status,
    output logic                 m_valid,
    input  wire                  m_ready,
    output lz4d_pkg::out_item_t  m_payload
);
    import lz4d_pkg::*;

    localparam logic [3:0] LANES = 4'(OUT_LANES);

    logic [7:0]        mem [WINDOW_BYTES];
    logic [7:0]        rd_data_reg;

    in_item_t          in_reg;
    phase_t            phase_reg, phase_next;
    logic [7:0]        token_reg, token_next;
    logic [31:0]       litrem_reg, litrem_next;
    logic [15:0]       off_reg, off_next;
    logic [15:0]       prod_reg, prod_next;
    logic [ADDR_W-1:0] widx_reg, widx_next;
    logic [7:0]        crem_reg, crem_next;
    logic [1:0]        status_reg, status_next;
    logic [63:0]       pack_reg, pack_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_payload_reg, m_payload_next;

    logic              we;
    logic [7:0]        wdata;
    logic              lit_put;
    logic              copy_go;
    logic [7:0]        copy_len;
    logic              out_free;
    logic [15:0]       new_off;
    logic [31:0]       lit_sum;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        phase_next  = phase_reg;
        token_next  = token_reg;
        litrem_next = litrem_reg;
        off_next    = off_reg;
        status_next = status_reg;
        lit_put     = 1'b0;
        copy_go     = 1'b0;
        copy_len    = 8'd0;
        new_off     = {in_reg.in_byte, off_reg[7:0]};
        lit_sum     = litrem_reg + {24'd0, in_reg.in_byte};
        if (dp_cmd.decode) begin
            status_next = STATUS_OK;
            case (in_reg.op)
                OP_FEED: begin
                    case (phase_reg)
                        PH_TOKEN: begin
                            token_next  = in_reg.in_byte;
                            litrem_next = {28'd0, in_reg.in_byte[7:4]};
                            if (in_reg.in_byte[7:4] == NIBBLE_EXT) phase_next = PH_LITLEN;
                            else if (in_reg.in_byte[7:4] != 4'd0) phase_next = PH_LITERALS;
                            else phase_next = PH_OFFLO;
                        end
                        PH_LITLEN: begin
                            litrem_next = lit_sum;
                            if (in_reg.in_byte != LEN_EXTEND) begin
                                phase_next = (lit_sum != 32'd0) ? PH_LITERALS : PH_OFFLO;
                            end
                        end
                        PH_LITERALS: begin
                            lit_put     = 1'b1;
                            litrem_next = litrem_reg - 32'd1;
                            if (litrem_reg == 32'd1) phase_next = PH_OFFLO;
                        end
                        PH_OFFLO: begin
                            off_next   = {8'd0, in_reg.in_byte};
                            phase_next = PH_OFFHI;
                        end
                        PH_OFFHI: begin
                            off_next = new_off;
                            if (new_off == 16'd0) begin
                                status_next = STATUS_BADOFF;
                            end else begin
                                phase_next = (token_reg[3:0] == NIBBLE_EXT) ?
                                             PH_MATCHLEN : PH_TOKEN;
                                copy_len   = {4'd0, token_reg[3:0]} + MATCH_MIN;
                                if (new_off > prod_reg) status_next = STATUS_BADOFF;
                                else copy_go = 1'b1;
                            end
                        end
                        PH_MATCHLEN: begin
                            if (in_reg.in_byte != LEN_EXTEND) phase_next = PH_TOKEN;
                            copy_len = in_reg.in_byte;
                            if (off_reg > prod_reg) status_next = STATUS_BADOFF;
                            else copy_go = (in_reg.in_byte != 8'd0);
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                OP_END: begin
                    if ((phase_reg != PH_TOKEN) && (phase_reg != PH_OFFLO)) begin
                        status_next = STATUS_TRUNC;
                    end
                    phase_next = PH_TOKEN;
                end
                OP_START: begin
                    phase_next = PH_TOKEN;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        we             = lit_put || dp_cmd.copy_wr;
        wdata          = lit_put ? in_reg.in_byte : rd_data_reg;
        widx_next      = widx_reg;
        prod_next      = prod_reg;
        crem_next      = crem_reg;
        pack_next      = pack_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        if (dp_cmd.decode) begin
            crem_next = copy_len;
            if (in_reg.op == OP_START) begin
                widx_next = '0;
                prod_next = 16'd0;
            end
        end
        if (we) begin
            widx_next = widx_reg + 1'b1;
            if (prod_reg != 16'hFFFF) prod_next = prod_reg + 16'd1;
            pack_next = pack_reg | ({56'd0, wdata} << {cnt_reg, 3'b000});
            cnt_next  = cnt_reg + 4'd1;
        end
        if (dp_cmd.copy_wr) crem_next = crem_reg - 8'd1;
        if (dp_cmd.emit) begin
            m_valid_next              = 1'b1;
            m_payload_next.out_bytes  = pack_reg;
            m_payload_next.byte_count = cnt_reg;
            m_payload_next.status     = status_reg;
            m_payload_next.last       = dp_cmd.emit_last;
            pack_next                 = 64'd0;
            cnt_next                  = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[widx_reg] <= wdata;
        if (dp_cmd.copy_rd) rd_data_reg <= mem[widx_reg - off_reg];
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) in_reg <= s_payload;
        status_reg    <= status_next;
        crem_reg      <= crem_next;
        m_payload_reg <= m_payload_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TOKEN;
            token_reg   <= 8'd0;
            litrem_reg  <= 32'd0;
            off_reg     <= 16'd0;
            prod_reg    <= 16'd0;
            widx_reg    <= '0;
            pack_reg    <= 64'd0;
            cnt_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            token_reg   <= token_next;
            litrem_reg  <= litrem_next;
            off_reg     <= off_next;
            prod_reg    <= prod_next;
            widx_reg    <= widx_next;
            pack_reg    <= pack_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign dp_status.copy_go   = copy_go;
    assign dp_status.copy_done = (crem_reg == 8'd1);
    assign dp_status.pack_full = ((cnt_reg + 4'd1) == LANES);
    assign dp_status.out_free  = out_free;
    assign m_valid             = m_valid_reg;
    assign m_payload           = m_payload_reg;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_emit_free, aclk, aresetn, !dp_cmd.emit || out_free)
    `ASSERT_ALWAYS(a_count_max, aclk, aresetn, !m_valid_reg || (m_payload_reg.byte_count <= LANES))
    `ASSERT_ALWAYS(a_partial_full, aclk, aresetn, !m_valid_reg || m_payload_reg.last || (m_payload_reg.byte_count == LANES))

endmodule

`default_nettype wire

FILE: hdl/lz4_block_stream_decoder.sv
// An item with no copy passes through ST_IDLE (load), ST_DECODE and ST_FLUSH,
// which registers its result once the output is free. Each match copy byte is
// a history read (ST_COPY_RD), then a write (ST_COPY_WR), with one result
// transfer per filled group of OUT_LANES bytes; the decoder takes one item at
// a time. Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
// LZ4 block stream decoder
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4_block_stream_decoder #(
    parameter int unsigned OUT_LANES = 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  lz4d_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  wire                 m_ready,
    output lz4d_pkg::out_item_t m_payload
);
    import lz4d_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    lz4d_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    lz4d_datapath #(
        .OUT_LANES (OUT_LANES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

FILE: sim/tb_lz4_block_stream_decoder.sv
// ----------------------------------------------------------------------------
// LZ4 block stream decoder testbench
// Runs a short table of directed transfers, then random LZ4 sequences mixed
// with noise. A behavioral decoder predicts the results of untyped items;
// each result is compared field by field with the oldest expected entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lz4_block_stream_decoder;
    import lz4d_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  in_byte;
        bit          typed;
        logic [1:0]  status;
    } row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    out_item_t expected_q[$];
    int        errors = 0;
    int        n_sent = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;

    phase_t      dec_phase;
    logic [7:0]  dec_token;
    logic [31:0] dec_lit_left;
    logic [15:0] dec_offset;
    logic [15:0] dec_produced;
    logic [15:0] dec_wr_idx;
    logic [7:0]  dec_history [0:65535];
    logic [7:0]  decoded_q[$];

    lz4_block_stream_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always #10 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("[lz4_block_stream_decoder] ERROR");
        $finish;
    end

    function automatic void put_decoded(logic [7:0] v);
        dec_history[dec_wr_idx] = v;
        dec_wr_idx = dec_wr_idx + 16'd1;
        if (dec_produced != 16'hFFFF) dec_produced = dec_produced + 16'd1;
        decoded_q.push_back(v);
    endfunction

    function automatic logic [1:0] copy_match(int unsigned len);
        if (dec_offset > dec_produced) return STATUS_BADOFF;
        for (int unsigned i = 0; i < len; i++)
            put_decoded(dec_history[16'(dec_wr_idx - dec_offset)]);
        return STATUS_OK;
    endfunction

    function automatic logic [1:0] decode_byte(logic [7:0] v);
        int unsigned ml;
        case (dec_phase)
            PH_TOKEN: begin
                dec_token = v;
                dec_lit_left = 32'(v[7:4]);
                if (v[7:4] == NIBBLE_EXT) dec_phase = PH_LITLEN;
                else dec_phase = (dec_lit_left != 0) ? PH_LITERALS : PH_OFFLO;
            end
            PH_LITLEN: begin
                dec_lit_left = dec_lit_left + 32'(v);
                if (v != LEN_EXTEND)
                    dec_phase = (dec_lit_left != 0) ? PH_LITERALS : PH_OFFLO;
            end
            PH_LITERALS: begin
                put_decoded(v);
                dec_lit_left = dec_lit_left - 32'd1;
                if (dec_lit_left == 0) dec_phase = PH_OFFLO;
            end
            PH_OFFLO: begin
                dec_offset = {8'd0, v};
                dec_phase = PH_OFFHI;
            end
            PH_OFFHI: begin
                dec_offset[15:8] = v;
                if (dec_offset == 0) return STATUS_BADOFF;
                ml = dec_token[3:0];
                dec_phase = (dec_token[3:0] == NIBBLE_EXT) ? PH_MATCHLEN : PH_TOKEN;
                return copy_match(ml + MATCH_MIN);
            end
            PH_MATCHLEN: begin
                if (v != LEN_EXTEND) dec_phase = PH_TOKEN;
                return copy_match(v);
            end
            default: ;
        endcase
        return STATUS_OK;
    endfunction

    function automatic void decode_transfer(in_item_t it, output out_item_t res[$]);
        logic [1:0] st;
        int         nres;
        out_item_t  w;
        st = STATUS_OK;
        decoded_q.delete();
        res.delete();
        if (it.op == OP_FEED) begin
            st = decode_byte(it.in_byte);
        end else if (it.op == OP_END) begin
            st = (dec_phase == PH_TOKEN || dec_phase == PH_OFFLO) ? STATUS_OK : STATUS_TRUNC;
            dec_phase = PH_TOKEN;
        end else if (it.op == OP_START) begin
            dec_wr_idx = 0;
            dec_produced = 0;
            dec_phase = PH_TOKEN;
        end
        nres = (decoded_q.size() == 0) ? 1 : (decoded_q.size() + 7) / 8;
        for (int r = 0; r < nres; r++) begin
            w = '0;
            for (int k = 0; k < 8 && decoded_q.size() > 0; k++) begin
                w.out_bytes[8*k +: 8] = decoded_q.pop_front();
                w.byte_count = w.byte_count + 4'd1;
            end
            w.status = st;
            w.last = (r == nres - 1);
            res.push_back(w);
        end
    endfunction

    task automatic send_item(in_item_t it, bit typed = 0, logic [1:0] typed_st = STATUS_OK);
        out_item_t res[$];
        int        gap;
        gap = (!calm && $urandom_range(99) < 16) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_payload <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        decode_transfer(it, res);
        if (typed) expected_q.push_back('{out_bytes: '0, byte_count: '0,
                                          status: typed_st, last: 1'b1});
        else foreach (res[i]) expected_q.push_back(res[i]);
    endtask

    task automatic send_feed(logic [7:0] v);
        send_item('{op: OP_FEED, in_byte: v});
    endtask

    task automatic send_sequence();
        int unsigned lits, mlen, lim, limit_off;
        lits = $urandom_range(99) < 30 ? 0 : $urandom_range(20, 1);
        if ($urandom_range(99) < 12) lits = 15 + $urandom_range(6);
        if (dec_produced == 0 && lits == 0) lits = 1;
        mlen = ($urandom_range(99) < 25) ? 15 : $urandom_range(14);
        send_feed({(lits >= 15) ? 4'd15 : 4'(lits), 4'(mlen)});
        if (lits >= 15) begin
            lim = lits - 15;
            while (lim >= 255) begin
                send_feed(LEN_EXTEND);
                lim -= 255;
            end
            send_feed(8'(lim));
        end
        repeat (lits) send_feed(8'($urandom));
        limit_off = dec_produced;
        if ($urandom_range(99) < 80 && limit_off > 16) limit_off = 16;
        lim = $urandom_range(limit_off, 1);
        send_feed(8'(lim));
        send_feed(8'(lim >> 8));
        if (mlen == 15) begin
            while ($urandom_range(99) < 20) send_feed(LEN_EXTEND);
            send_feed(8'($urandom_range(30)));
        end
        if ($urandom_range(99) < 10) send_item('{op: OP_END, in_byte: 8'($urandom)});
    endtask

    initial begin : receiver
        int hold;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_payload);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_payload.out_bytes !== e.out_bytes) begin
                    $display("%0t: out_bytes expected %h actual %h",
                             $time, e.out_bytes, m_payload.out_bytes);
                    errors++;
                end
                if (m_payload.byte_count !== e.byte_count) begin
                    $display("%0t: byte_count expected %0d actual %0d",
                             $time, e.byte_count, m_payload.byte_count);
                    errors++;
                end
                if (m_payload.status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, m_payload.status);
                    errors++;
                end
                if (m_payload.last !== e.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, e.last, m_payload.last);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        row_t rows[$];
        bit   held;
        bit   paused;
        dec_phase = PH_TOKEN;
        dec_token = 0;
        dec_lit_left = 0;
        dec_offset = 0;
        dec_produced = 0;
        dec_wr_idx = 0;
        held = 1'b0;
        paused = 1'b0;
        rows = '{
            '{OP_END,    8'h00, 1, STATUS_OK},
            '{OP_UNUSED, 8'hFF, 1, STATUS_OK},
            '{OP_FEED,   8'h30, 1, STATUS_OK},
            '{OP_FEED,   8'h41, 0, STATUS_OK},
            '{OP_FEED,   8'h00, 0, STATUS_OK},
            '{OP_FEED,   8'hFF, 0, STATUS_OK},
            '{OP_FEED,   8'h00, 1, STATUS_OK},
            '{OP_FEED,   8'h00, 1, STATUS_BADOFF},
            '{OP_FEED,   8'h01, 0, STATUS_OK},
            '{OP_FEED,   8'h0F, 1, STATUS_OK},
            '{OP_FEED,   8'h02, 1, STATUS_OK},
            '{OP_FEED,   8'h00, 0, STATUS_OK},
            '{OP_FEED,   8'hFF, 0, STATUS_OK},
            '{OP_FEED,   8'h00, 1, STATUS_OK},
            '{OP_FEED,   8'h00, 1, STATUS_OK},
            '{OP_FEED,   8'hFF, 1, STATUS_OK},
            '{OP_FEED,   8'hFF, 1, STATUS_BADOFF},
            '{OP_FEED,   8'h10, 1, STATUS_OK},
            '{OP_END,    8'h00, 1, STATUS_TRUNC},
            '{OP_FEED,   8'h00, 1, STATUS_OK},
            '{OP_END,    8'h00, 1, STATUS_OK},
            '{OP_START,  8'h00, 1, STATUS_OK},
            '{OP_FEED,   8'h0F, 1, STATUS_OK},
            '{OP_FEED,   8'h01, 1, STATUS_OK},
            '{OP_FEED,   8'h00, 1, STATUS_BADOFF},
            '{OP_FEED,   8'h00, 1, STATUS_BADOFF}
        };
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (rows[i]) send_item('{op: rows[i].op, in_byte: rows[i].in_byte},
                                    rows[i].typed, rows[i].status);

        while (n_sent < 170) begin
            if (!held && n_sent > 40) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            calm = (n_sent >= 90 && n_sent < 130);
            if (!paused && n_sent > 60) begin
                paused = 1'b1;
                @(negedge aclk) s_valid <= 1'b0;
                wait (expected_q.size() == 0);
            end
            if ($urandom_range(99) < 85) begin
                send_sequence();
            end else begin
                send_item('{op: 2'($urandom), in_byte: 8'($urandom)});
            end
        end
        calm = 1'b0;
        @(negedge aclk) s_valid <= 1'b0;

        wait (expected_q.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("[lz4_block_stream_decoder] OK");
        end else begin
            $display("[lz4_block_stream_decoder] ERROR");
        end
        $finish;
    end

endmodule
